[hdl/gaps_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gaps_pkg
// shared types, codes and helper functions of the grid path search block
// ----------------------------------------------------------------------------
package gaps_pkg;

   localparam int COST_W        = 16;
   localparam int DIR_W         = 3;
   localparam int CNT_W         = 13;
   localparam int STRAIGHT_COST = 10;
   localparam int DIAG_COST     = 14;
   localparam logic [3:0] NB_LAST   = 4'd8;
   localparam logic [3:0] NB_CENTER = 4'd4;

   localparam logic [1:0] OP_WRITE_CELL = 2'd0;
   localparam logic [1:0] OP_RUN_SEARCH = 2'd1;
   localparam logic [1:0] OP_READ_PATH  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_PATH  = 2'd1;
   localparam logic [1:0] STATUS_BEYOND   = 2'd2;

   localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
   localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
   localparam logic [2:0] REG_START_COL   = 3'd2;
   localparam logic [2:0] REG_START_ROW   = 3'd3;
   localparam logic [2:0] REG_GOAL_COL    = 3'd4;
   localparam logic [2:0] REG_GOAL_ROW    = 3'd5;

   typedef struct packed {
      logic [1:0]  op;
      logic [5:0]  cell_col;
      logic [5:0]  cell_row;
      logic        cell_open;
      logic [11:0] path_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [12:0] path_length;
      logic [5:0]  step_col;
      logic [5:0]  step_row;
      logic [12:0] expansions;
   } rsp_type;

   typedef struct packed {
      logic [6:0] grid_width;
      logic [6:0] grid_height;
      logic [5:0] start_col;
      logic [5:0] start_row;
      logic [5:0] goal_col;
      logic [5:0] goal_row;
   } cfg_type;

   typedef struct packed {
      logic              open_mark;
      logic              closed_mark;
      logic [DIR_W-1:0]  dir;
      logic [COST_W-1:0] cost;
   } node_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_MAP_RD,
      ST_CLEAR,
      ST_SEED,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_PICK,
      ST_NB_RD,
      ST_NB_S1,
      ST_NB_S2,
      ST_NB_EV,
      ST_TR_WR,
      ST_TR_PAR,
      ST_RESP
   } state_type;

   // neighbor slot 0..8 -> {dy+1, dx+1}
   function automatic logic [3:0] nb_offset(input logic [3:0] slot);
      logic [3:0] r;
      case (slot)
         4'd0: r = {2'd0, 2'd0};
         4'd1: r = {2'd0, 2'd1};
         4'd2: r = {2'd0, 2'd2};
         4'd3: r = {2'd1, 2'd0};
         4'd4: r = {2'd1, 2'd1};
         4'd5: r = {2'd1, 2'd2};
         4'd6: r = {2'd2, 2'd0};
         4'd7: r = {2'd2, 2'd1};
         4'd8: r = {2'd2, 2'd2};
         default: r = {2'd1, 2'd1};
      endcase
      return r;
   endfunction

   function automatic logic [DIR_W-1:0] dir_of_slot(input logic [3:0] slot);
      logic [3:0] r;
      r = (slot < 4'd4) ? slot : slot - 4'd1;
      return r[DIR_W-1:0];
   endfunction

   function automatic logic [3:0] slot_of_dir(input logic [DIR_W-1:0] k);
      logic [3:0] r;
      r = (k < 3'd4) ? {1'b0, k} : {1'b0, k} + 4'd1;
      return r;
   endfunction

   // octile distance: 10 * max + 4 * min
   function automatic logic [COST_W-1:0] octile(input logic [7:0] dx, input logic [7:0] dy);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = (dx < dy) ? dx : dy;
      hi = (dx < dy) ? dy : dx;
      return COST_W'(hi) * COST_W'(STRAIGHT_COST)
           + COST_W'(lo) * COST_W'(DIAG_COST - STRAIGHT_COST);
   endfunction

endpackage
`default_nettype wire

[hdl/gaps_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gaps_engine
// map, node and route memories with the search and trace sequencer
// ----------------------------------------------------------------------------
module gaps_engine
   import gaps_pkg::*;
#(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req,
   input  wire cfg_type cfg,
   input  wire logic    res_take,
   output logic         ready,
   output logic         res_valid,
   output rsp_type      res
);

   localparam int CB         = $clog2(MAX_COLS);
   localparam int RB         = $clog2(MAX_ROWS);
   localparam int AB         = CB + RB;
   localparam int DEPTH      = 1 << AB;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int LEN_W      = $clog2(CELL_COUNT + 1);

   state_type state_ff, state_in;

   logic [AB-1:0] sweep_ff, sweep_in;

   logic          walk_mem [DEPTH];
   logic          walk_we, walk_wdata, walk_rd_ff;
   logic [AB-1:0] walk_waddr, walk_raddr;

   node_type      node_mem [DEPTH];
   logic          node_we;
   node_type      node_wdata, node_rd_ff;
   logic [AB-1:0] node_waddr, node_raddr;

   logic [AB-1:0] route_mem [DEPTH];
   logic          route_we;
   logic [AB-1:0] route_waddr, route_raddr, route_wdata, route_rd_ff;

   logic [AB-1:0] s_addr_ff, s_addr_in, g_addr_ff, g_addr_in;
   logic [CB-1:0] scan_c_ff, scan_c_in;
   logic [RB-1:0] scan_r_ff, scan_r_in;
   logic          s1_valid_ff, s1_valid_in;
   logic [AB-1:0] s1_addr_ff, s1_addr_in;

   logic              any_ff, any_in;
   logic [AB-1:0]     best_addr_ff, best_addr_in;
   logic [COST_W:0]   best_f_ff, best_f_in;
   logic [COST_W-1:0] best_h_ff, best_h_in;
   logic [COST_W-1:0] best_cost_ff, best_cost_in;
   logic [DIR_W-1:0]  best_dir_ff, best_dir_in;

   logic [3:0]    nb_i_ff, nb_i_in;
   logic [AB-1:0] nb_addr_ff, nb_addr_in;
   logic          nb_diag_ff, nb_diag_in;
   node_type      nb_node_ff, nb_node_in;
   logic          walk_n_ff, walk_n_in, side1_ff, side1_in;

   logic [AB-1:0]    tr_cur_ff, tr_cur_in;
   logic [LEN_W-1:0] tr_n_ff, tr_n_in;

   logic [LEN_W-1:0] route_len_ff, route_len_in, expand_ff, expand_in;
   logic             found_ff, found_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [5:0]       res_col_ff, res_col_in, res_row_ff, res_row_in;

   // region size after clamping
   logic [8:0] w9, h9, gw9, gh9;
   assign gw9 = 9'(cfg.grid_width);
   assign gh9 = 9'(cfg.grid_height);
   assign w9  = (gw9 == 9'd0) ? 9'd1 : ((gw9 > 9'(MAX_COLS)) ? 9'(MAX_COLS) : gw9);
   assign h9  = (gh9 == 9'd0) ? 9'd1 : ((gh9 > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : gh9);

   logic region_ok;
   assign region_ok = (9'(cfg.start_col) < w9) && (9'(cfg.start_row) < h9) &&
                      (9'(cfg.goal_col) < w9) && (9'(cfg.goal_row) < h9);

   logic cell_in_map;
   assign cell_in_map = (9'(req.cell_col) < 9'(MAX_COLS)) && (9'(req.cell_row) < 9'(MAX_ROWS));

   logic [7:0] cc8, cr8, sc8, sr8, gc8, gr8;
   assign cc8 = 8'(req.cell_col);
   assign cr8 = 8'(req.cell_row);
   assign sc8 = 8'(cfg.start_col);
   assign sr8 = 8'(cfg.start_row);
   assign gc8 = 8'(cfg.goal_col);
   assign gr8 = 8'(cfg.goal_row);

   logic path_ok;
   assign path_ok = found_ff && (LEN_W'(req.path_index) < route_len_ff) &&
                    (13'(req.path_index) < 13'(route_len_ff));

   logic scan_last;
   assign scan_last = (9'(scan_c_ff) == w9 - 9'd1) && (9'(scan_r_ff) == h9 - 9'd1);

   // scan evaluation of the word read in the previous cycle
   logic [7:0]        e_col8, e_row8, e_dx, e_dy;
   logic [COST_W-1:0] e_h;
   logic [COST_W:0]   e_f;
   logic              e_better;
   assign e_col8   = 8'(s1_addr_ff[CB-1:0]);
   assign e_row8   = 8'(s1_addr_ff[AB-1:CB]);
   assign e_dx     = (e_col8 > gc8) ? e_col8 - gc8 : gc8 - e_col8;
   assign e_dy     = (e_row8 > gr8) ? e_row8 - gr8 : gr8 - e_row8;
   assign e_h      = octile(e_dx, e_dy);
   assign e_f      = (COST_W+1)'(node_rd_ff.cost) + (COST_W+1)'(e_h);
   assign e_better = s1_valid_ff && node_rd_ff.open_mark &&
                     (!any_ff || (e_f < best_f_ff) || ((e_f == best_f_ff) && (e_h < best_h_ff)));

   // neighbor of the expanded cell
   logic [3:0]    nb_off;
   logic [1:0]    nb_dxp, nb_dyp;
   logic [9:0]    nc_ext, nr_ext;
   logic          nb_ok;
   logic [CB-1:0] nb_c;
   logic [RB-1:0] nb_r;
   assign nb_off = nb_offset(nb_i_ff);
   assign nb_dxp = nb_off[1:0];
   assign nb_dyp = nb_off[3:2];
   assign nc_ext = 10'(best_addr_ff[CB-1:0]) + 10'(nb_dxp);
   assign nr_ext = 10'(best_addr_ff[AB-1:CB]) + 10'(nb_dyp);
   assign nb_ok  = (nb_i_ff != NB_CENTER) && (nc_ext != 10'd0) && (nr_ext != 10'd0) &&
                   (nc_ext <= 10'(w9)) && (nr_ext <= 10'(h9));
   assign nb_c   = CB'(nc_ext - 10'd1);
   assign nb_r   = RB'(nr_ext - 10'd1);

   logic [COST_W-1:0] nb_g;
   logic              nb_take;
   assign nb_g    = best_cost_ff + (nb_diag_ff ? COST_W'(DIAG_COST) : COST_W'(STRAIGHT_COST));
   assign nb_take = walk_n_ff && !nb_node_ff.closed_mark &&
                    (!nb_diag_ff || (side1_ff && walk_rd_ff)) &&
                    (!nb_node_ff.open_mark || (nb_g < nb_node_ff.cost));

   // parent step of the trace, kept one above the parent position
   logic [3:0]    tp_off;
   logic [9:0]    pc_ext, pr_ext;
   logic          tp_ok;
   logic          tr_done;
   assign tp_off  = nb_offset(slot_of_dir(node_rd_ff.dir));
   assign pc_ext  = 10'(tr_cur_ff[CB-1:0]) + 10'd2 - 10'(tp_off[1:0]);
   assign pr_ext  = 10'(tr_cur_ff[AB-1:CB]) + 10'd2 - 10'(tp_off[3:2]);
   assign tp_ok   = (pc_ext != 10'd0) && (pr_ext != 10'd0) &&
                    (pc_ext <= 10'(MAX_COLS)) && (pr_ext <= 10'(MAX_ROWS));
   assign tr_done = (tr_cur_ff == s_addr_ff) || ((tr_n_ff + LEN_W'(1)) == LEN_W'(CELL_COUNT));

   logic [7:0] rc8, rr8;
   assign rc8 = 8'(route_rd_ff[CB-1:0]);
   assign rr8 = 8'(route_rd_ff[AB-1:CB]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (&sweep_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               case (req.op)
                  OP_RUN_SEARCH: state_in = region_ok ? ST_CLEAR : ST_RESP;
                  OP_READ_PATH:  state_in = path_ok ? ST_MAP_RD : ST_RESP;
                  default:       state_in = ST_RESP;
               endcase
            end
         end
         ST_MAP_RD:    state_in = ST_RESP;
         ST_CLEAR: begin
            if (&sweep_ff) state_in = ST_SEED;
         end
         ST_SEED:      state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_last) state_in = ST_SCAN_LAST;
         end
         ST_SCAN_LAST: state_in = ST_PICK;
         ST_PICK: begin
            if (!any_ff) state_in = ST_RESP;
            else if (best_addr_ff == g_addr_ff) state_in = ST_TR_WR;
            else state_in = ST_NB_RD;
         end
         ST_NB_RD: begin
            if (nb_ok) state_in = ST_NB_S1;
            else if (nb_i_ff == NB_LAST) state_in = ST_SCAN;
         end
         ST_NB_S1:     state_in = ST_NB_S2;
         ST_NB_S2:     state_in = ST_NB_EV;
         ST_NB_EV:     state_in = (nb_i_ff == NB_LAST) ? ST_SCAN : ST_NB_RD;
         ST_TR_WR:     state_in = tr_done ? ST_RESP : ST_TR_PAR;
         ST_TR_PAR:    state_in = tp_ok ? ST_TR_WR : ST_RESP;
         ST_RESP: begin
            if (res_take) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      sweep_in      = sweep_ff;
      walk_we       = 1'b0;
      walk_waddr    = sweep_ff;
      walk_wdata    = 1'b1;
      walk_raddr    = '0;
      node_we       = 1'b0;
      node_waddr    = sweep_ff;
      node_wdata    = '0;
      node_raddr    = '0;
      route_we      = 1'b0;
      route_waddr   = tr_n_ff[AB-1:0];
      route_wdata   = tr_cur_ff;
      route_raddr   = '0;
      s_addr_in     = s_addr_ff;
      g_addr_in     = g_addr_ff;
      scan_c_in     = scan_c_ff;
      scan_r_in     = scan_r_ff;
      s1_valid_in   = 1'b0;
      s1_addr_in    = {scan_r_ff, scan_c_ff};
      any_in        = any_ff;
      best_addr_in  = best_addr_ff;
      best_f_in     = best_f_ff;
      best_h_in     = best_h_ff;
      best_cost_in  = best_cost_ff;
      best_dir_in   = best_dir_ff;
      nb_i_in       = nb_i_ff;
      nb_addr_in    = nb_addr_ff;
      nb_diag_in    = nb_diag_ff;
      nb_node_in    = nb_node_ff;
      walk_n_in     = walk_n_ff;
      side1_in      = side1_ff;
      tr_cur_in     = tr_cur_ff;
      tr_n_in       = tr_n_ff;
      route_len_in  = route_len_ff;
      expand_in     = expand_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_col_in    = res_col_ff;
      res_row_in    = res_row_ff;

      if (e_better) begin
         any_in       = 1'b1;
         best_addr_in = s1_addr_ff;
         best_f_in    = e_f;
         best_h_in    = e_h;
         best_cost_in = node_rd_ff.cost;
         best_dir_in  = node_rd_ff.dir;
      end

      case (state_ff)
         ST_INIT: begin
            walk_we  = 1'b1;
            sweep_in = sweep_ff + AB'(1);
         end
         ST_IDLE: begin
            res_status_in = STATUS_OK;
            res_col_in    = '0;
            res_row_in    = '0;
            if (start) begin
               case (req.op)
                  OP_WRITE_CELL: begin
                     walk_we    = cell_in_map;
                     walk_waddr = {cr8[RB-1:0], cc8[CB-1:0]};
                     walk_wdata = req.cell_open;
                  end
                  OP_RUN_SEARCH: begin
                     found_in      = 1'b0;
                     route_len_in  = '0;
                     expand_in     = '0;
                     res_status_in = STATUS_NO_PATH;
                     sweep_in      = '0;
                     s_addr_in     = {sr8[RB-1:0], sc8[CB-1:0]};
                     g_addr_in     = {gr8[RB-1:0], gc8[CB-1:0]};
                  end
                  OP_READ_PATH: begin
                     if (!found_ff) res_status_in = STATUS_NO_PATH;
                     else if (!path_ok) res_status_in = STATUS_BEYOND;
                     // the trace stores the route goal first
                     route_raddr = AB'(route_len_ff - LEN_W'(1) - LEN_W'(req.path_index));
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MAP_RD: begin
            res_col_in = rc8[5:0];
            res_row_in = rr8[5:0];
         end
         ST_CLEAR: begin
            node_we  = 1'b1;
            sweep_in = sweep_ff + AB'(1);
         end
         ST_SEED: begin
            node_we    = 1'b1;
            node_waddr = s_addr_ff;
            node_wdata = '{open_mark: 1'b1, closed_mark: 1'b0, dir: '0, cost: '0};
            scan_c_in  = '0;
            scan_r_in  = '0;
            any_in     = 1'b0;
         end
         ST_SCAN: begin
            node_raddr  = {scan_r_ff, scan_c_ff};
            s1_valid_in = 1'b1;
            if (9'(scan_c_ff) == w9 - 9'd1) begin
               scan_c_in = '0;
               scan_r_in = scan_r_ff + RB'(1);
            end else begin
               scan_c_in = scan_c_ff + CB'(1);
            end
         end
         ST_PICK: begin
            if (any_ff) begin
               node_we    = 1'b1;
               node_waddr = best_addr_ff;
               node_wdata = '{open_mark: 1'b0, closed_mark: 1'b1, dir: best_dir_ff,
                              cost: best_cost_ff};
               expand_in  = expand_ff + LEN_W'(1);
               nb_i_in    = '0;
               tr_cur_in  = best_addr_ff;
               tr_n_in    = '0;
               if (best_addr_ff == g_addr_ff) found_in = 1'b1;
            end
         end
         ST_NB_RD: begin
            walk_raddr = {nb_r, nb_c};
            node_raddr = {nb_r, nb_c};
            nb_addr_in = {nb_r, nb_c};
            nb_diag_in = (nb_dxp != 2'd1) && (nb_dyp != 2'd1);
            if (!nb_ok) begin
               nb_i_in = nb_i_ff + 4'd1;
               if (nb_i_ff == NB_LAST) begin
                  scan_c_in = '0;
                  scan_r_in = '0;
                  any_in    = 1'b0;
               end
            end
         end
         ST_NB_S1: begin
            walk_n_in  = walk_rd_ff;
            nb_node_in = node_rd_ff;
            walk_raddr = {nb_addr_ff[AB-1:CB], best_addr_ff[CB-1:0]};
         end
         ST_NB_S2: begin
            side1_in   = walk_rd_ff;
            walk_raddr = {best_addr_ff[AB-1:CB], nb_addr_ff[CB-1:0]};
         end
         ST_NB_EV: begin
            if (nb_take) begin
               node_we    = 1'b1;
               node_waddr = nb_addr_ff;
               node_wdata = '{open_mark: 1'b1, closed_mark: 1'b0,
                              dir: dir_of_slot(nb_i_ff), cost: nb_g};
            end
            nb_i_in = nb_i_ff + 4'd1;
            if (nb_i_ff == NB_LAST) begin
               scan_c_in = '0;
               scan_r_in = '0;
               any_in    = 1'b0;
            end
         end
         ST_TR_WR: begin
            route_we   = 1'b1;
            tr_n_in    = tr_n_ff + LEN_W'(1);
            node_raddr = tr_cur_ff;
            if (tr_done) begin
               route_len_in  = tr_n_ff + LEN_W'(1);
               res_status_in = STATUS_OK;
            end
         end
         ST_TR_PAR: begin
            if (tp_ok) begin
               tr_cur_in = {RB'(pr_ext - 10'd1), CB'(pc_ext - 10'd1)};
            end else begin
               route_len_in  = tr_n_ff;
               res_status_in = STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (walk_we) walk_mem[walk_waddr] <= walk_wdata;
      walk_rd_ff <= walk_mem[walk_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_waddr] <= node_wdata;
      node_rd_ff <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (route_we) route_mem[route_waddr] <= route_wdata;
      route_rd_ff <= route_mem[route_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         any_ff       <= 1'b0;
         found_ff     <= 1'b0;
         route_len_ff <= '0;
         expand_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         s1_valid_ff  <= s1_valid_in;
         any_ff       <= any_in;
         found_ff     <= found_in;
         route_len_ff <= route_len_in;
         expand_ff    <= expand_in;
      end
   end

   always_ff @(posedge clock) begin
      s_addr_ff     <= s_addr_in;
      g_addr_ff     <= g_addr_in;
      scan_c_ff     <= scan_c_in;
      scan_r_ff     <= scan_r_in;
      s1_addr_ff    <= s1_addr_in;
      best_addr_ff  <= best_addr_in;
      best_f_ff     <= best_f_in;
      best_h_ff     <= best_h_in;
      best_cost_ff  <= best_cost_in;
      best_dir_ff   <= best_dir_in;
      nb_i_ff       <= nb_i_in;
      nb_addr_ff    <= nb_addr_in;
      nb_diag_ff    <= nb_diag_in;
      nb_node_ff    <= nb_node_in;
      walk_n_ff     <= walk_n_in;
      side1_ff      <= side1_in;
      tr_cur_ff     <= tr_cur_in;
      tr_n_ff       <= tr_n_in;
      res_status_ff <= res_status_in;
      res_col_ff    <= res_col_in;
      res_row_ff    <= res_row_in;
   end

   assign ready     = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_RESP);
   always_comb begin
      res.status      = res_status_ff;
      res.found       = found_ff;
      res.path_length = CNT_W'(route_len_ff);
      res.step_col    = res_col_ff;
      res.step_row    = res_row_ff;
      res.expansions  = CNT_W'(expand_ff);
   end

`ifndef SYNTH
   a_found_has_route: assert property (@(posedge clock) disable iff (reset)
      (found_ff && state_ff == ST_IDLE) |-> (route_len_ff != '0))
      else $error("found search with empty route");

   a_goal_starts_trace: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK && any_ff && best_addr_ff == g_addr_ff)
      |=> (state_ff == ST_TR_WR && found_ff))
      else $error("goal expansion did not start trace");

   a_scan_starts_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && $past(state_ff) != ST_SCAN) |-> (!any_ff && !s1_valid_ff))
      else $error("open set scan started with stale best");
`endif

endmodule
`default_nettype wire

[hdl/grid_astar_path_search_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grid_astar_path_search_top
// A* search over a walkable grid map with configuration registers
// ----------------------------------------------------------------------------
// After reset the map is swept to all walkable, one cell a cycle over the
// whole map memory, and no request is taken meanwhile. A map write or an
// unused op code goes from idle straight to its response word; a path read
// in range first reads the route memory. A search first clears its node
// memory, then each expansion scans every cell of the region in use through
// the node memory's single read port and visits its neighbors: one inside the
// region is read, its two side cells are read and it is evaluated, one outside
// is skipped. A found path is traced back, each path cell written to the route
// memory before the step to its parent. One request is worked on at a time;
// the response register lets the next request enter while a response waits.
module grid_astar_path_search_top
   import gaps_pkg::*;
#(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [6:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic    eng_ready, eng_res_valid, res_take, start;
   rsp_type eng_res;

   assign csr_ready = 1'b1;
   assign req_ready = eng_ready;
   assign start     = req_valid && eng_ready;
   // the response word slot is free or drains this cycle
   assign res_take  = !rsp_valid_ff || rsp_ready;

   gaps_engine #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .cfg       (cfg_ff),
      .res_take  (res_take),
      .ready     (eng_ready),
      .res_valid (eng_res_valid),
      .res       (eng_res)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GRID_WIDTH:  cfg_in.grid_width  = csr_data;
            REG_GRID_HEIGHT: cfg_in.grid_height = csr_data;
            REG_START_COL:   cfg_in.start_col   = csr_data[5:0];
            REG_START_ROW:   cfg_in.start_row   = csr_data[5:0];
            REG_GOAL_COL:    cfg_in.goal_col    = csr_data[5:0];
            REG_GOAL_ROW:    cfg_in.goal_row    = csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (eng_res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{grid_width: 7'd64, grid_height: 7'd64, start_col: '0,
                           start_row: '0, goal_col: '0, goal_row: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_goal_row_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == REG_GOAL_ROW)
      |=> (cfg_ff.goal_row == $past(csr_data[5:0])))
      else $error("goal row register not written");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("response word dropped or changed while waiting");

   a_rsp_from_engine: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !eng_res_valid) |=> !rsp_valid_ff)
      else $error("response word raised without an engine result");
`endif

endmodule
`default_nettype wire
